>>> hdl/ubxd_pkg.sv
// ----------------------------------------------------------------------------
// ubxd_pkg
// shared types and constants of the ubx frame deframer and router
// ----------------------------------------------------------------------------
`default_nettype none

package ubxd_pkg;

  // sync pattern of a frame
  localparam logic [7:0] SYNC_ONE = 8'hB5;
  localparam logic [7:0] SYNC_TWO = 8'h62;

  // reset values of the configuration registers
  localparam logic [15:0] MAX_LEN_RST     = 16'd1024;
  localparam logic [7:0]  ROUTE_CLASS_RST = 8'h01;
  localparam logic [7:0]  ROUTE_ID_RST    = 8'h07;

  // register indexes (byte address is 4x)
  localparam int unsigned  APB_AW        = 4;
  localparam logic [1:0]   REG_MAX_LEN   = 2'd0;
  localparam logic [1:0]   REG_ROUTE_CLS = 2'd1;
  localparam logic [1:0]   REG_ROUTE_ID  = 2'd2;

  // frame status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CK_ERR   = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  typedef enum logic [3:0] {
    PH_HUNT1   = 4'd0,
    PH_HUNT2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK_A    = 4'd7,
    PH_CK_B    = 4'd8
  } phase_e;

  typedef struct packed {
    logic [15:0] max_len;
    logic [7:0]  route_class;
    logic [7:0]  route_id;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic        frame_end;
    logic [1:0]  frame_status;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_length;
    logic        to_data_queue;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/ubxd_in_if.sv
// ----------------------------------------------------------------------------
// ubxd_in_if
// byte stream channel into the deframer
// ----------------------------------------------------------------------------
`default_nettype none

interface ubxd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> hdl/ubxd_out_if.sv
// ----------------------------------------------------------------------------
// ubxd_out_if
// result channel out of the deframer
// ----------------------------------------------------------------------------
`default_nettype none

interface ubxd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [15:0] byte_index;
  logic        frame_end;
  logic [1:0]  frame_status;
  logic [7:0]  msg_class;
  logic [7:0]  msg_id;
  logic [15:0] payload_length;
  logic        to_data_queue;

  modport source (
    output valid, output data_byte, output byte_index, output frame_end,
    output frame_status, output msg_class, output msg_id,
    output payload_length, output to_data_queue, input ready
  );
  modport sink (
    input valid, input data_byte, input byte_index, input frame_end,
    input frame_status, input msg_class, input msg_id,
    input payload_length, input to_data_queue, output ready
  );
endinterface

`default_nettype wire

>>> hdl/ubxd_cfg_regs.sv
// ----------------------------------------------------------------------------
// ubxd_cfg_regs
// apb register file: max payload length and routed class/id
// ----------------------------------------------------------------------------
`default_nettype none

module ubxd_cfg_regs
  import ubxd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_MAX_LEN:   cfg_d.max_len     = pwdata[15:0];
        REG_ROUTE_CLS: cfg_d.route_class = pwdata[7:0];
        REG_ROUTE_ID:  cfg_d.route_id    = pwdata[7:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_len     <= MAX_LEN_RST;
      cfg_q.route_class <= ROUTE_CLASS_RST;
      cfg_q.route_id    <= ROUTE_ID_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_LEN:   prdata = {16'd0, cfg_q.max_len};
      REG_ROUTE_CLS: prdata = {24'd0, cfg_q.route_class};
      REG_ROUTE_ID:  prdata = {24'd0, cfg_q.route_id};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> hdl/ubxd_parser.sv
// ----------------------------------------------------------------------------
// ubxd_parser
// frame state machine with fletcher-8 running sums, one byte per step
// ----------------------------------------------------------------------------
`default_nettype none

module ubxd_parser
  import ubxd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  wire cfg_t       cfg_i,
  output logic            emit_o,
  output result_t         res_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic [7:0]  cls_q, cls_d, id_q, id_d, rcv_a_q, rcv_a_d;
  logic [15:0] len_q, len_d, seen_q, seen_d;

  logic [7:0]  base_a, base_b, add_a, add_b;
  logic [15:0] len_full;
  logic [16:0] seen_inc;
  logic        sum_en;
  logic        ck_good;

  // fletcher sums restart at the class byte
  assign base_a   = (phase_q == PH_CLASS) ? 8'd0 : sum_a_q;
  assign base_b   = (phase_q == PH_CLASS) ? 8'd0 : sum_b_q;
  assign add_a    = base_a + byte_i;
  assign add_b    = base_b + add_a;
  assign len_full = {byte_i, len_q[7:0]};
  assign seen_inc = {1'b0, seen_q} + 17'd1;
  assign ck_good  = (rcv_a_q == sum_a_q) && (byte_i == sum_b_q);

  always_comb begin
    case (phase_q)
      PH_CLASS, PH_ID, PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD: sum_en = 1'b1;
      default:                                           sum_en = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    cls_d   = cls_q;
    id_d    = id_q;
    len_d   = len_q;
    seen_d  = seen_q;
    rcv_a_d = rcv_a_q;
    if (step_i) begin
      if (sum_en) begin
        sum_a_d = add_a;
        sum_b_d = add_b;
      end
      case (phase_q)
        PH_HUNT1: begin
          if (byte_i == SYNC_ONE) phase_d = PH_HUNT2;
        end
        PH_HUNT2: begin
          if (byte_i == SYNC_TWO)      phase_d = PH_CLASS;
          else if (byte_i != SYNC_ONE) phase_d = PH_HUNT1;
        end
        PH_CLASS: begin
          cls_d   = byte_i;
          phase_d = PH_ID;
        end
        PH_ID: begin
          id_d    = byte_i;
          phase_d = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_d   = {8'd0, byte_i};
          phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_d  = len_full;
          seen_d = 16'd0;
          if (len_full > cfg_i.max_len) phase_d = PH_HUNT1;
          else if (len_full == 16'd0)   phase_d = PH_CK_A;
          else                          phase_d = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          seen_d = seen_inc[15:0];
          if (seen_inc >= {1'b0, len_q}) phase_d = PH_CK_A;
        end
        PH_CK_A: begin
          rcv_a_d = byte_i;
          phase_d = PH_CK_B;
        end
        PH_CK_B: phase_d = PH_HUNT1;
        default: phase_d = PH_HUNT1;
      endcase
    end
  end

  // result of the current byte
  always_comb begin
    emit_o               = 1'b0;
    res_o.data_byte      = 8'd0;
    res_o.byte_index     = 16'd0;
    res_o.frame_end      = 1'b0;
    res_o.frame_status   = ST_OK;
    res_o.msg_class      = cls_q;
    res_o.msg_id         = id_q;
    res_o.payload_length = len_q;
    res_o.to_data_queue  = (cls_q == cfg_i.route_class) && (id_q == cfg_i.route_id);
    case (phase_q)
      PH_LEN_HI: begin
        res_o.payload_length = len_full;
        if (len_full > cfg_i.max_len) begin
          emit_o             = 1'b1;
          res_o.frame_end    = 1'b1;
          res_o.frame_status = ST_TOO_LONG;
        end
      end
      PH_PAYLOAD: begin
        emit_o           = 1'b1;
        res_o.data_byte  = byte_i;
        res_o.byte_index = seen_q;
      end
      PH_CK_B: begin
        emit_o             = 1'b1;
        res_o.frame_end    = 1'b1;
        res_o.frame_status = ck_good ? ST_OK : ST_CK_ERR;
      end
      default: emit_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT1;
      sum_a_q <= 8'd0;
      sum_b_q <= 8'd0;
      cls_q   <= 8'd0;
      id_q    <= 8'd0;
      len_q   <= 16'd0;
      seen_q  <= 16'd0;
      rcv_a_q <= 8'd0;
    end else begin
      phase_q <= phase_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      cls_q   <= cls_d;
      id_q    <= id_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      rcv_a_q <= rcv_a_d;
    end
  end

`ifndef ASSERT_OFF
  a_payload_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (seen_q < len_q))
    else $error("payload counter ran past the frame length");

  a_ckb_resyncs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (phase_q == PH_CK_B)) |=> (phase_q == PH_HUNT1))
    else $error("parser did not resync after the checksum");

  a_emit_closes_or_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && emit_o && res_o.frame_end) |=> (phase_q == PH_HUNT1))
    else $error("frame end without returning to sync hunt");
`endif

endmodule

`default_nettype wire

>>> hdl/ubxd_top.sv
// ----------------------------------------------------------------------------
// ubx_frame_deframer_router_top
// byte-serial ubx deframer with cut-through payload and route flag
// ----------------------------------------------------------------------------
`default_nettype none

// Takes one received byte per clock on rx_i and hunts for ubx frames
// (sync b5 62, class, id, little-endian length, payload, ck_a, ck_b).
// Every payload byte comes out on res_o as soon as it is parsed, with its
// index, the frame's class/id/length and the route flag. One closing result
// with frame_end set carries the status: ok, checksum error, or too long
// (length above max_payload_len, reported right after the length bytes,
// after which the rest of the frame is treated as stream bytes). Other bytes
// give no result. A byte passes an input register, the parser logic and a
// result register, and a byte can be accepted every cycle; the input
// register only stalls when the result register is full and not being
// drained. Registers: 0x0 max_payload_len, 0x4 route_class, 0x8 route_id,
// written through the apb port while the stream is quiet.

module ubx_frame_deframer_router_top
  import ubxd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  ubxd_in_if.sink                rx_i,
  ubxd_out_if.source             res_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  cfg_t       cfg;
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       out_vld_q, out_vld_d;
  result_t    res_q;
  result_t    res_n;
  logic       emit;
  logic       advance;
  logic       rx_take;

  // register file
  ubxd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // the registered byte moves on when the result slot is free or draining
  assign advance    = in_vld_q && (!out_vld_q || res_o.ready);
  assign rx_i.ready = !in_vld_q || advance;
  assign rx_take    = rx_i.valid && rx_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (rx_take)      in_vld_d = 1'b1;
    else if (advance) in_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_vld_q <= 1'b0;
    else         in_vld_q <= in_vld_d;
  end

  // input byte register, data only, no reset
  always_ff @(posedge clk_i) begin
    if (rx_take) in_byte_q <= rx_i.rx_byte;
  end

  ubxd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .cfg_i  (cfg),
    .emit_o (emit),
    .res_o  (res_n)
  );

  // result register
  always_comb begin
    out_vld_d = out_vld_q;
    if (advance)          out_vld_d = emit;
    else if (res_o.ready) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else         out_vld_q <= out_vld_d;
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) res_q <= res_n;
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.data_byte      = res_q.data_byte;
  assign res_o.byte_index     = res_q.byte_index;
  assign res_o.frame_end      = res_q.frame_end;
  assign res_o.frame_status   = res_q.frame_status;
  assign res_o.msg_class      = res_q.msg_class;
  assign res_o.msg_id         = res_q.msg_id;
  assign res_o.payload_length = res_q.payload_length;
  assign res_o.to_data_queue  = res_q.to_data_queue;

`ifndef ASSERT_OFF
  a_end_has_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.frame_end) |->
      ((res_q.data_byte == 8'd0) && (res_q.byte_index == 16'd0)))
    else $error("frame end result carries payload data");

  a_payload_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res_q.frame_end) |-> (res_q.frame_status == ST_OK))
    else $error("payload result carries a non-ok status");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_i.ready |-> (in_vld_q && out_vld_q && !res_o.ready))
    else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire
